### hw/rtl/shs_pkg.sv
// Shared types, constants and helpers of the stepper homing sequencer.
package shs_pkg;

	localparam int unsigned SETTLE_TICKS = 5;
	localparam int unsigned TIMER_BITS   = 16;
	localparam int unsigned CMD_W        = 2;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 16;
	localparam int unsigned DWELL_W      = 16;
	localparam int unsigned COUNT_W      = 16;

	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_HOME   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SINGLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DWELL    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF  = 2'd2;

	localparam logic [DWELL_W-1:0] DWELL_RESET   = 16'd1000;
	localparam logic [COUNT_W-1:0] BACKOFF_RESET = 16'd0;

	typedef logic [TIMER_BITS-1:0] timer_t;

	typedef enum logic [6:0] {
		PH_IDLE        = 7'b0000001,
		PH_SETTLE      = 7'b0000010,
		PH_SEEK        = 7'b0000100,
		PH_SEEK_DWELL  = 7'b0001000,
		PH_BACK_SETTLE = 7'b0010000,
		PH_BACK        = 7'b0100000,
		PH_BACK_DWELL  = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic                switch_polarity;
		logic [DWELL_W-1:0]  dwell_ticks;
		logic [COUNT_W-1:0]  backoff_steps;
	} cfg_t;

	typedef struct packed {
		logic step_pulse;
		logic direction_out;
		logic motor_enable;
		logic switch_hit;
		logic busy;
		logic done;
	} res_t;

	localparam logic [63:0] TIMER_MAX = (64'd1 << TIMER_BITS) - 64'd1;

	// Saturate a load value at the timer maximum
	function automatic timer_t sat_load(input logic [31:0] v);
		timer_t r;
		if ({32'd0, v} > TIMER_MAX) begin
			r = '1;
		end else begin
			r = v[TIMER_BITS-1:0];
		end
		return r;
	endfunction

endpackage

### hw/rtl/shs_cfg_regs.sv
// Configuration register file of the stepper homing sequencer.
module shs_cfg_regs
	import shs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.switch_polarity <= 1'b0;
			cfg_q.dwell_ticks     <= DWELL_RESET;
			cfg_q.backoff_steps   <= BACKOFF_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POLARITY: cfg_q.switch_polarity <= cfg_data[0];
				REG_DWELL:    cfg_q.dwell_ticks     <= cfg_data[DWELL_W-1:0];
				REG_BACKOFF:  cfg_q.backoff_steps   <= cfg_data[COUNT_W-1:0];
				default:      cfg_q                 <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/shs_core.sv
// Homing state machine: phase, timers, counters and per-tick result.
module shs_core
	import shs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [CMD_W-1:0] command,
	input  logic             direction,
	input  logic             switch_level,
	input  cfg_t             cfg,
	output res_t             res
);

	phase_t               phase_q, phase_d;
	timer_t               timer_q, timer_d;
	logic [COUNT_W-1:0]   count_q, count_d;
	logic                 seek_dir_q, seek_dir_d;
	logic                 enabled_q, enabled_d;
	logic                 dir_line_q, dir_line_d;
	logic                 single_q, single_d;
	logic                 hit;
	logic                 wait_end;
	timer_t               timer_dec;
	logic                 pulse;
	logic                 done;

	assign hit       = (switch_level == cfg.switch_polarity);
	assign wait_end  = (timer_q <= timer_t'(1));
	assign timer_dec = wait_end ? '0 : timer_q - timer_t'(1);

	always_comb begin
		phase_d    = phase_q;
		timer_d    = timer_q;
		count_d    = count_q;
		seek_dir_d = seek_dir_q;
		enabled_d  = enabled_q;
		dir_line_d = dir_line_q;
		single_d   = single_q;
		pulse      = 1'b0;
		done       = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (command == CMD_HOME || command == CMD_SINGLE) begin
					enabled_d  = 1'b1;
					seek_dir_d = direction;
					dir_line_d = direction;
					single_d   = (command == CMD_SINGLE);
					timer_d    = sat_load(32'(SETTLE_TICKS));
					phase_d    = PH_SETTLE;
				end
			end
			PH_SETTLE: begin
				timer_d = timer_dec;
				if (wait_end) begin
					phase_d = PH_SEEK;
				end
			end
			PH_SEEK: begin
				if (hit) begin
					if (single_q) begin
						done    = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						dir_line_d = ~seek_dir_q;
						count_d    = '0;
						timer_d    = sat_load(32'(SETTLE_TICKS));
						phase_d    = PH_BACK_SETTLE;
					end
				end else begin
					pulse   = 1'b1;
					timer_d = sat_load(32'(cfg.dwell_ticks));
					phase_d = PH_SEEK_DWELL;
				end
			end
			PH_SEEK_DWELL: begin
				timer_d = timer_dec;
				if (wait_end) begin
					if (single_q) begin
						done    = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_SEEK;
					end
				end
			end
			PH_BACK_SETTLE: begin
				timer_d = timer_dec;
				if (wait_end) begin
					phase_d = PH_BACK;
				end
			end
			PH_BACK: begin
				if (count_q >= cfg.backoff_steps) begin
					done    = 1'b1;
					phase_d = PH_IDLE;
				end else begin
					pulse   = 1'b1;
					count_d = count_q + COUNT_W'(1);
					timer_d = sat_load(32'(cfg.dwell_ticks));
					phase_d = PH_BACK_DWELL;
				end
			end
			PH_BACK_DWELL: begin
				timer_d = timer_dec;
				if (wait_end) begin
					phase_d = PH_BACK;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			timer_q    <= '0;
			count_q    <= '0;
			seek_dir_q <= 1'b0;
			enabled_q  <= 1'b0;
			dir_line_q <= 1'b0;
			single_q   <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			timer_q    <= timer_d;
			count_q    <= count_d;
			seek_dir_q <= seek_dir_d;
			enabled_q  <= enabled_d;
			dir_line_q <= dir_line_d;
			single_q   <= single_d;
		end
	end

	assign res.step_pulse    = pulse;
	assign res.direction_out = dir_line_d;
	assign res.motor_enable  = enabled_d;
	assign res.switch_hit    = hit;
	assign res.busy          = (phase_d != PH_IDLE);
	assign res.done          = done;

endmodule

### hw/rtl/shs_out_reg.sv
// Result register with valid and ready toward the receiver.
module shs_out_reg
	import shs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_d,
	input  logic out_ready,
	output logic out_valid,
	output logic take_ok,
	output res_t res_s1
);

	logic valid_q;

	assign take_ok = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_ok) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s1 <= res_d;
		end
	end

	assign out_valid = valid_q;

endmodule

### hw/rtl/stepper_homing_sequencer.sv
// Top level of the stepper homing sequencer.
// Each input item is one time tick carrying a command, the direction toward
// the endstop and the sampled raw switch level. A start command enables the
// driver, settles, steps toward the switch with a dwell after each pulse,
// then reverses, settles and steps away by the configured back-off count.
// A single-step command settles, samples the switch and steps once if clear.
// Every tick yields exactly one result item: step pulse, direction line,
// enable, qualified switch state, busy and done.
// The result is valid in the cycle after input accept; one item is taken per
// cycle while the result register can take it, limited by the phase and timer update loop.
// The result register frees as it is taken, so input ready is high whenever
// the register is empty or the receiver takes it in that cycle; a stalled
// receiver holds the result and stops input acceptance until it drains.
// Reset clears the sequence to idle with the driver disabled and loads the
// register defaults (polarity 0, dwell 1000 ticks, no back-off).
// Configuration writes are always taken; indexes beyond the list are dropped.
module stepper_homing_sequencer
	import shs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      command,
	input  logic                  direction,
	input  logic                  switch_level,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  step_pulse,
	output logic                  direction_out,
	output logic                  motor_enable,
	output logic                  switch_hit,
	output logic                  busy_res,
	output logic                  done_res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	res_t res_d;
	res_t res_s1;
	logic accept;
	logic take_ok;

	assign cfg_ready = 1'b1;
	assign in_ready  = take_ok;
	assign accept    = in_valid && take_ok;

	shs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	shs_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command      (command),
		.direction    (direction),
		.switch_level (switch_level),
		.cfg          (cfg),
		.res          (res_d)
	);

	shs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res_d     (res_d),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.take_ok   (take_ok),
		.res_s1    (res_s1)
	);

	assign step_pulse    = res_s1.step_pulse;
	assign direction_out = res_s1.direction_out;
	assign motor_enable  = res_s1.motor_enable;
	assign switch_hit    = res_s1.switch_hit;
	assign busy_res      = res_s1.busy;
	assign done_res      = res_s1.done;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item produced no result");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("sequence reported done while still busy");

	a_pulse_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_pulse |-> motor_enable && busy_res)
		else $error("step pulse without enabled driver or running sequence");

endmodule

### tb/testbench.sv
// Self-checking testbench for the stepper homing sequencer with its tick predictor.
import shs_pkg::*;

class homing_scoreboard;
	res_t                 expected_q[$];
	int                   mismatches;
	logic                 polarity;
	logic [DWELL_W-1:0]   dwell;
	logic [COUNT_W-1:0]   backoff;
	phase_t               phase;
	timer_t               timer;
	logic [COUNT_W-1:0]   pulses;
	logic                 seek_dir;
	logic                 enabled;
	logic                 dir_line;
	logic                 single_step;

	function new();
		mismatches  = 0;
		polarity    = 1'b0;
		dwell       = DWELL_RESET;
		backoff     = BACKOFF_RESET;
		phase       = PH_IDLE;
		timer       = '0;
		pulses      = '0;
		seek_dir    = 1'b0;
		enabled     = 1'b0;
		dir_line    = 1'b0;
		single_step = 1'b0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_POLARITY: polarity = data[0];
			REG_DWELL:    dwell = data;
			REG_BACKOFF:  backoff = data;
			default: ;
		endcase
	endfunction

	// count down a wait, true on its last tick
	function bit timer_done();
		if (timer > 1) begin
			timer = timer - 1'b1;
			return 1'b0;
		end
		timer = '0;
		return 1'b1;
	endfunction

	function void note_tick(logic [CMD_W-1:0] cmd, logic dir, logic lvl);
		res_t r;
		logic hit;
		hit = (lvl == polarity);
		r = '0;
		case (phase)
			PH_IDLE: begin
				if (cmd == CMD_HOME || cmd == CMD_SINGLE) begin
					enabled     = 1'b1;
					seek_dir    = dir;
					dir_line    = dir;
					single_step = (cmd == CMD_SINGLE);
					timer       = timer_t'(SETTLE_TICKS);
					phase       = PH_SETTLE;
				end
			end
			PH_SETTLE: begin
				if (timer_done()) phase = PH_SEEK;
			end
			PH_SEEK: begin
				if (hit) begin
					if (single_step) begin
						r.done = 1'b1;
						phase  = PH_IDLE;
					end else begin
						dir_line = ~seek_dir;
						pulses   = '0;
						timer    = timer_t'(SETTLE_TICKS);
						phase    = PH_BACK_SETTLE;
					end
				end else begin
					r.step_pulse = 1'b1;
					timer        = dwell;
					phase        = PH_SEEK_DWELL;
				end
			end
			PH_SEEK_DWELL: begin
				if (timer_done()) begin
					if (single_step) begin
						r.done = 1'b1;
						phase  = PH_IDLE;
					end else begin
						phase = PH_SEEK;
					end
				end
			end
			PH_BACK_SETTLE: begin
				if (timer_done()) phase = PH_BACK;
			end
			PH_BACK: begin
				if (pulses >= backoff) begin
					r.done = 1'b1;
					phase  = PH_IDLE;
				end else begin
					r.step_pulse = 1'b1;
					pulses       = pulses + 1'b1;
					timer        = dwell;
					phase        = PH_BACK_DWELL;
				end
			end
			PH_BACK_DWELL: begin
				if (timer_done()) phase = PH_BACK;
			end
			default: phase = PH_IDLE;
		endcase
		r.direction_out = dir_line;
		r.motor_enable  = enabled;
		r.switch_hit    = hit;
		r.busy          = (phase != PH_IDLE);
		expected_q.push_back(r);
	endfunction

	function void check_result(res_t got);
		res_t want;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result item %p", got);
			return;
		end
		want = expected_q.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("result mismatch: pulse %b/%b dir %b/%b en %b/%b hit %b/%b busy %b/%b done %b/%b",
					want.step_pulse, got.step_pulse, want.direction_out, got.direction_out,
					want.motor_enable, got.motor_enable, want.switch_hit, got.switch_hit,
					want.busy, got.busy, want.done, got.done);
			end
		end
	endfunction
endclass

module testbench;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 3000;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [CMD_W-1:0]      command      = CMD_TICK;
	logic                  direction    = 1'b0;
	logic                  switch_level = 1'b0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic                  step_pulse;
	logic                  direction_out;
	logic                  motor_enable;
	logic                  switch_hit;
	logic                  busy_res;
	logic                  done_res;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = REG_POLARITY;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	bit idle_on  = 1'b1;
	bit hold_req = 1'b0;
	int stall_cycles = 0;
	homing_scoreboard sb = new();

	stepper_homing_sequencer uut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(res_t'({step_pulse, direction_out, motor_enable, switch_hit,
				busy_res, done_res}));
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : receiver
		int n;
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				n = 0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 19);
			end else begin
				out_ready <= 1'b1;
				n = $urandom_range(1, 40);
			end
			repeat (n) @(posedge clk);
		end
	end

	task automatic send_tick(logic [CMD_W-1:0] cmd, logic dir, logic lvl);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		direction    <= dir;
		switch_level <= lvl;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		sb.note_tick(cmd, dir, lvl);
	endtask

	task automatic hold_ticks(int n, logic lvl);
		repeat (n) send_tick(CMD_TICK, 1'($urandom), lvl);
	endtask

	// well-formed commands with random switch timing, plus some noise
	task automatic random_tick();
		logic [CMD_W-1:0] cmd;
		logic lvl;
		if ($urandom_range(0, 9) == 0) begin
			send_tick(CMD_W'($urandom), 1'($urandom), 1'($urandom));
		end else begin
			if (sb.phase == PH_IDLE) begin
				case ($urandom_range(0, 5))
					0:       cmd = CMD_SINGLE;
					1:       cmd = CMD_TICK;
					default: cmd = CMD_HOME;
				endcase
			end else begin
				cmd = ($urandom_range(0, 7) == 0) ? CMD_W'($urandom) : CMD_TICK;
			end
			lvl = ($urandom_range(0, 5) == 0) ? sb.polarity : ~sb.polarity;
			send_tick(cmd, 1'($urandom), lvl);
		end
	endtask

	task automatic set_config(logic pol, logic [DWELL_W-1:0] dw, logic [COUNT_W-1:0] bo);
		logic [CFG_IDX_W-1:0]  idx[3];
		logic [CFG_DATA_W-1:0] val[3];
		idx = '{REG_POLARITY, REG_DWELL, REG_BACKOFF};
		val = '{CFG_DATA_W'(pol), dw, bo};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(negedge clk); while (!cfg_ready);
			@(posedge clk);
			sb.write_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [DWELL_W-1:0] dw;
		logic [COUNT_W-1:0] bo;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(1'b1, 16'd0, 16'd1);
		send_tick(CMD_UNUSED, 1'b1, 1'b0);
		send_tick(CMD_TICK, 1'b0, 1'b1);
		send_tick(CMD_SINGLE, 1'b1, 1'b1);
		send_tick(CMD_HOME, 1'b0, 1'b0);
		hold_ticks(4, 1'b0);
		hold_ticks(1, 1'b1);
		send_tick(CMD_HOME, 1'b0, 1'b0);
		hold_ticks(5, 1'b0);
		hold_ticks(2, 1'b0);
		hold_ticks(1, 1'b1);
		hold_ticks(5, 1'b0);
		hold_ticks(4, 1'b1);

		drain_results();
		idle_on = 1'b0;
		set_config(1'b0, 16'hFFFF, 16'd0);
		send_tick(CMD_SINGLE, 1'b1, 1'b0);
		while (sb.phase != PH_IDLE) send_tick(CMD_TICK, 1'($urandom), 1'b0);
		drain_results();
		set_config(1'b1, 16'd0, 16'd50);
		send_tick(CMD_HOME, 1'b0, 1'b0);
		while (sb.phase != PH_IDLE) random_tick();
		idle_on = 1'b1;

		for (int p = 0; p < 12; p++) begin
			drain_results();
			idle_on = (p < 10);
			dw = ($urandom_range(0, 4) == 0) ? DWELL_W'($urandom_range(4, 12)) :
				DWELL_W'($urandom_range(0, 3));
			bo = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(4, 9)) :
				COUNT_W'($urandom_range(0, 3));
			if (p == 1) bo = '0;
			set_config(1'($urandom), dw, bo);
			if (p == 3) begin
				hold_req = 1'b1;
				while (hold_req) random_tick();
			end
			repeat (65) random_tick();
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
